// File: design/ate_pkg.sv
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types and constants of the array table engine: request kinds,
// status codes, field widths and the command word broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ate_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;

  localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] K_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] K_SEARCH = 3'd2;
  localparam logic [KIND_W-1:0] K_SORT   = 3'd3;
  localparam logic [KIND_W-1:0] K_DUMP   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT,
    OP_ROTATE,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic                phase;
    logic [WORD_W-1:0]   value;
    logic [IDX_W-1:0]    index;
    logic [CNT_W-1:0]    count;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/ate_cell.sv
// ----------------------------------------------------------------------------
// ate_cell
// One storage cell of the word chain. It loads an appended word, takes its
// right neighbor's word on a delete or a rotation, and swaps with a neighbor
// during an odd-even transposition pass of the sort.
// ----------------------------------------------------------------------------
`default_nettype none

module ate_cell #(
  parameter int IDX = 0
) (
  input  wire logic                   clk,
  input  wire ate_pkg::cell_cmd_t     cmd,
  input  wire logic [31:0]            left,
  input  wire logic [31:0]            right,
  input  wire logic                   swap_in,
  output logic                        swap_out,
  output logic [31:0]                 word
);
  import ate_pkg::*;

  localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);
  localparam logic             PARITY   = 1'(IDX % 2);

  assign swap_out = (cmd.op == OP_SORT) && (cmd.phase == PARITY) &&
                    (POS_NEXT < cmd.count) && ($signed(word) > $signed(right));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        if (POS == cmd.count) word <= cmd.value;
      end
      OP_SHIFT: begin
        if ((POS >= {1'b0, cmd.index}) && (POS_NEXT < cmd.count)) word <= right;
      end
      OP_ROTATE: begin
        word <= right;
      end
      OP_SORT: begin
        if (swap_out) begin
          word <= right;
        end else if (swap_in) begin
          word <= left;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/array_table_engine.sv
// ----------------------------------------------------------------------------
// array_table_engine
// Packed array of signed words held in a chain of cells, with append,
// delete, search, sort and dump requests.
// ----------------------------------------------------------------------------
// A request arrives as one transfer on the s_ channel: the kind in s_tuser,
// the value and index in s_tdata. Results leave on the m_ channel through an
// output register; m_tlast marks the final result of a request.
// Append and delete act on the chain in the cycle of the transfer and give
// their result through the response state. Search rotates the whole chain
// past cell 0 and then answers through the response state. Sort runs DEPTH
// odd-even transposition passes over neighboring cell pairs. Dump rotates
// the whole chain once around and emits one word per cycle while the
// receiver takes them; a stall on m_tready holds the rotation.
// A new request is taken only while no request is in progress; the pending
// result of the previous one may still wait in the output register.
// Unknown kinds are taken and dropped. Reset empties the array and clears
// m_tvalid; stored words and the output data are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module array_table_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // operand_value[31:0], operand_index[37:32], zero pad
  input  wire logic [2:0]  s_tuser,   // kind[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // status[2:0], found_index[8:3], element[40:9],
                                      // element_count[47:41]
  output logic             m_tlast    // last
);
  import ate_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] STEP_END = CNT_W'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SORT = 5'b00010,
    S_SCAN = 5'b00100,
    S_DUMP = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    step, step_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                found, found_next;
  logic [STAT_W-1:0]   res_status, res_status_next;
  logic [IDX_W-1:0]    res_index, res_index_next;
  logic [WORD_W-1:0]   opnd, opnd_next;

  logic                slot_free;
  logic                load_out;
  logic [STAT_W-1:0]   out_status;
  logic [IDX_W-1:0]    out_index;
  logic [WORD_W-1:0]   out_elem;
  logic                out_last;
  logic                dump_emit;
  logic                dump_adv;
  logic                hit;

  logic [WORD_W-1:0]   in_value;
  logic [IDX_W-1:0]    in_index;

  cell_cmd_t           cmd;
  logic [WORD_W-1:0]   cell_word [DEPTH];
  logic                cell_swap [DEPTH];

  assign in_value  = s_tdata[31:0];
  assign in_index  = s_tdata[37:32];
  assign s_tready  = (state == S_IDLE) && !rst;
  assign slot_free = !m_tvalid || m_tready;
  assign dump_emit = (step < count);
  assign dump_adv  = !dump_emit || slot_free;
  assign hit       = (step < count) && !found && (cell_word[0] == opnd);

  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.phase = step[0];
    cmd.value = in_value;
    cmd.index = in_index;
    cmd.count = count;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          if ((s_tuser == K_APPEND) && (count < DEPTH_C)) begin
            cmd.op = OP_LOAD;
          end else if ((s_tuser == K_DELETE) && (count != '0) &&
                       ({1'b0, in_index} < count)) begin
            cmd.op = OP_SHIFT;
          end
        end
      end
      S_SORT: cmd.op = OP_SORT;
      S_SCAN: cmd.op = OP_ROTATE;
      S_DUMP: if (dump_adv) cmd.op = OP_ROTATE;
      S_RESP: cmd.op = OP_HOLD;
      default: cmd.op = OP_HOLD;
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    logic              swap_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
      assign swap_w = 1'b0;
    end else begin : g_mid
      assign left_w = cell_word[k-1];
      assign swap_w = cell_swap[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = cell_word[0];
    end else begin : g_inner
      assign right_w = cell_word[k+1];
    end
    ate_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .left     (left_w),
      .right    (right_w),
      .swap_in  (swap_w),
      .swap_out (cell_swap[k]),
      .word     (cell_word[k])
    );
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    count_next      = count;
    found_next      = found;
    res_status_next = res_status;
    res_index_next  = res_index;
    opnd_next       = opnd;
    load_out        = 1'b0;
    out_status      = res_status;
    out_index       = res_index;
    out_elem        = '0;
    out_last        = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          step_next       = '0;
          found_next      = 1'b0;
          res_index_next  = '0;
          res_status_next = ST_OK;
          opnd_next       = in_value;
          unique case (s_tuser)
            K_APPEND: begin
              if (count < DEPTH_C) begin
                count_next = count + CNT_W'(1);
              end else begin
                res_status_next = ST_FULL;
              end
              state_next = S_RESP;
            end
            K_DELETE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if ({1'b0, in_index} >= count) begin
                res_status_next = ST_BADIDX;
              end else begin
                count_next = count - CNT_W'(1);
              end
              state_next = S_RESP;
            end
            K_SEARCH: state_next = S_SCAN;
            K_SORT:   state_next = S_SORT;
            K_DUMP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESP;
              end else begin
                state_next = S_DUMP;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SORT: begin
        step_next = step + CNT_W'(1);
        if (step == STEP_END) state_next = S_RESP;
      end
      S_SCAN: begin
        step_next = step + CNT_W'(1);
        if (hit) begin
          found_next     = 1'b1;
          res_index_next = step[IDX_W-1:0];
        end
        if (step == STEP_END) begin
          res_status_next = (found || hit) ? ST_OK : ST_NOTFOUND;
          state_next      = S_RESP;
        end
      end
      S_DUMP: begin
        if (dump_adv) begin
          step_next = step + CNT_W'(1);
          if (dump_emit) begin
            load_out   = 1'b1;
            out_status = ST_OK;
            out_index  = '0;
            out_elem   = cell_word[0];
            out_last   = ((step + CNT_W'(1)) == count);
          end
          if (step == STEP_END) state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      count    <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      count <= count_next;
      found <= found_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_index  <= res_index_next;
    opnd       <= opnd_next;
    if (load_out) begin
      m_tdata <= {count, out_elem, out_index, out_status};
      m_tlast <= out_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("element count exceeds depth");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT || state == S_SCAN || state == S_DUMP) |-> step <= STEP_END)
    else $error("chain step counter ran past the last cell");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == K_APPEND && count < DEPTH_C)
      |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the element count");

endmodule

`default_nettype wire
